### rtl/ula_steering_vector_generator_macros.svh
// ----------------------------------------------------------------------------
// ula_steering_vector_generator_macros
// assertion macros of the steering vector generator rtl
// ----------------------------------------------------------------------------
`ifndef ULA_STEERING_VECTOR_GENERATOR_MACROS_SVH
`define ULA_STEERING_VECTOR_GENERATOR_MACROS_SVH

// property checked on every clock edge, ignored while reset is held
`define USVG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// property checked on every clock edge, reset included
`define USVG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/usvg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usvg_pkg
// types, constants and helper functions of the steering vector generator
// ----------------------------------------------------------------------------
package usvg_pkg;

    // default sizes
    localparam int MAX_ELEMENTS_DEF  = 64;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;
    localparam int KW                = $clog2(TABLE_LEN);

    // datapath widths
    localparam int CW       = 34;   // cordic x, y, z
    localparam int PHW      = 32;   // phase, 2^32 is one turn
    localparam int ACCW     = 42;   // element phase accumulator, Q.42 turns
    localparam int IDXW     = 6;
    localparam int NUMW     = 7;
    localparam int SPW      = 16;
    localparam int OUTW     = 16;
    localparam int ANGW     = 16;
    localparam int OTDW     = 40;   // output tdata, 38 bits padded to bytes
    localparam int CFG_IDXW = 8;
    localparam int CFG_DW   = 16;

    // register indexes
    localparam logic [CFG_IDXW-1:0] REG_NUM_ELEMENTS    = 8'd0;
    localparam logic [CFG_IDXW-1:0] REG_ELEMENT_SPACING = 8'd1;

    // register reset values
    localparam logic [NUMW-1:0] NUM_ELEMENTS_RST    = 7'd8;
    localparam logic [SPW-1:0]  ELEMENT_SPACING_RST = 16'd2048;

    // fixed point constants
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;
    localparam logic signed [CW-1:0] MONE_Q30 = -34'sd1073741824;
    localparam logic [PHW-1:0]       EIGHTH   = 32'h2000_0000;
    localparam logic [ACCW-1:0]      RND_HALF = 42'd512;
    localparam logic signed [18:0]   Q14_MAX  = 19'sd16384;
    localparam logic signed [18:0]   Q14_MIN  = -19'sd16384;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_THETA,
        S_STEP,
        S_ELEM,
        S_WAIT,
        S_EMIT
    } t_state;

    // request to the rotator
    typedef struct packed {
        logic           start;
        logic [PHW-1:0] phase;
    } t_cordic_req;

    // rotator result, held until the next request
    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] cos_v;
        logic signed [CW-1:0] sin_v;
    } t_cordic_res;

    // atan(2^-k) in units of 2^-32 turn
    function automatic logic signed [CW-1:0] atan_turn(input logic [KW-1:0] k);
        logic [31:0] t;
        unique case (k)
            5'd0:    t = 32'h2000_0000;
            5'd1:    t = 32'h12E4_051E;
            5'd2:    t = 32'h09FB_385B;
            5'd3:    t = 32'h0511_11D4;
            5'd4:    t = 32'h028B_0D43;
            5'd5:    t = 32'h0145_D7E1;
            5'd6:    t = 32'h00A2_F61E;
            5'd7:    t = 32'h0051_7C55;
            5'd8:    t = 32'h0028_BE53;
            5'd9:    t = 32'h0014_5F2F;
            5'd10:   t = 32'h000A_2F98;
            5'd11:   t = 32'h0005_17CC;
            5'd12:   t = 32'h0002_8BE6;
            5'd13:   t = 32'h0001_45F3;
            5'd14:   t = 32'h0000_A2F9;
            5'd15:   t = 32'h0000_517C;
            5'd16:   t = 32'h0000_28BE;
            5'd17:   t = 32'h0000_145F;
            5'd18:   t = 32'h0000_0A2F;
            5'd19:   t = 32'h0000_0517;
            5'd20:   t = 32'h0000_028B;
            5'd21:   t = 32'h0000_0145;
            5'd22:   t = 32'h0000_00A2;
            5'd23:   t = 32'h0000_0051;
            default: t = 32'h0000_0000;
        endcase
        return $signed({2'b00, t});
    endfunction

    // Q2.30 to Q1.14 with rounding and saturation
    function automatic logic [OUTW-1:0] to_q14(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        logic signed [18:0] r;
        t = $signed({v[CW-1], v}) + (CW+1)'(32768);
        r = 19'(t >>> 16);
        if (r > Q14_MAX) begin
            r = Q14_MAX;
        end else if (r < Q14_MIN) begin
            r = Q14_MIN;
        end
        return r[OUTW-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/usvg_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usvg_cordic
// iterative rotation-mode cordic, one micro-rotation per clock
// ----------------------------------------------------------------------------
module usvg_cordic
    import usvg_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cordic_req i_req,
    output t_cordic_res      o_res
);

    localparam int NUM_ITER = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;
    localparam logic [KW-1:0] LAST_K = KW'(NUM_ITER - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [KW-1:0]        r_k;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic [1:0]           r_q;

    logic [PHW-1:0]       w_fold;
    logic [1:0]           w_q;
    logic [PHW-1:0]       w_ru;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [CW-1:0] w_at;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [CW-1:0] n_z;

    // fold the phase into an eighth turn around zero by a quadrant count
    always_comb begin
        w_fold = i_req.phase + EIGHTH;
        w_q    = w_fold[PHW-1:PHW-2];
        w_ru   = i_req.phase - {w_q, {(PHW-2){1'b0}}};
    end

    // shared shift and add unit
    always_comb begin
        w_dx = r_y >>> r_k;
        w_dy = r_x >>> r_k;
        w_at = atan_turn(r_k);
        if (!r_z[CW-1]) begin
            n_x = r_x - w_dx;
            n_y = r_y + w_dy;
            n_z = r_z - w_at;
        end else begin
            n_x = r_x + w_dx;
            n_y = r_y - w_dy;
            n_z = r_z + w_at;
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + KW'(1);
                if (r_k == LAST_K) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // rotation registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= GAIN_Q30;
            r_y <= '0;
            r_z <= CW'($signed(w_ru));
            r_q <= w_q;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    // turn back by whole quarter turns
    always_comb begin
        o_res.done = r_done;
        case (r_q)
            2'd1: begin
                o_res.cos_v = -r_y;
                o_res.sin_v = r_x;
            end
            2'd2: begin
                o_res.cos_v = -r_x;
                o_res.sin_v = -r_y;
            end
            2'd3: begin
                o_res.cos_v = r_y;
                o_res.sin_v = -r_x;
            end
            default: begin
                o_res.cos_v = r_x;
                o_res.sin_v = r_y;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/ula_steering_vector_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ula_steering_vector_generator
// steering vector of a uniform linear array from one arrival angle
// ----------------------------------------------------------------------------
// Each input transaction carries an angle (Q1.15 of pi); the block answers with
// one output transaction per array element, element order, tlast on the final
// one, each holding cos and sin of i * spacing * sin(angle) / 4096 turns in Q1.14.
// All sines and cosines come from one iterative cordic doing one micro-rotation
// per clock, so the rotator sets the rate: it first gets sin(angle) and the
// phase step, then rotates once per element, and a stalled sink holds the
// sequence. s_axis_tready is high only between angles; a pending final result
// does not hold off the next angle.
// ----------------------------------------------------------------------------
`include "ula_steering_vector_generator_macros.svh"

module ula_steering_vector_generator
    import usvg_pkg::*;
#(
    parameter int MAX_ELEMENTS  = MAX_ELEMENTS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input angles
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [ANGW-1:0]     s_axis_tdata,   // [15:0] angle
    // element results
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [OTDW-1:0]          m_axis_tdata,   // [5:0] element_index,
                                                     // [21:6] real_part,
                                                     // [37:22] imag_part,
                                                     // [39:38] zero
    output logic                     m_axis_tlast,   // last
    // register writes
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_IDXW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0]   i_cfg_data
);

    localparam logic [NUMW-1:0] M_MAX = NUMW'(MAX_ELEMENTS);

    t_state                r_state;
    t_state                n_state;
    logic [NUMW-1:0]       r_num_el;
    logic [SPW-1:0]        r_spacing;
    logic [IDXW-1:0]       r_idx;
    logic [IDXW-1:0]       n_idx;
    logic [ACCW-1:0]       r_acc;
    logic [ACCW-1:0]       n_acc;
    logic signed [31:0]    r_sin;
    logic signed [31:0]    n_sin;
    logic [ACCW-1:0]       r_step;
    logic [ACCW-1:0]       n_step;
    logic                  r_m_tvalid;
    logic                  n_m_tvalid;
    logic [OTDW-1:0]       r_m_tdata;
    logic [OTDW-1:0]       n_m_tdata;
    logic                  r_m_tlast;
    logic                  n_m_tlast;

    t_cordic_req           w_req;
    t_cordic_res           w_res;
    logic [NUMW-1:0]       w_m;
    logic                  w_last;
    logic                  w_out_free;
    logic                  w_in_acc;
    logic [ACCW-1:0]       w_acc_rnd;
    logic signed [48:0]    w_prod;
    logic signed [CW-1:0]  w_sclamp;

    // shared rotator
    usvg_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_el  <= NUM_ELEMENTS_RST;
            r_spacing <= ELEMENT_SPACING_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_NUM_ELEMENTS:    r_num_el  <= i_cfg_data[NUMW-1:0];
                REG_ELEMENT_SPACING: r_spacing <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // element count limited to one through the array size
    always_comb begin
        if (r_num_el == '0) begin
            w_m = NUMW'(1);
        end else if (r_num_el > M_MAX) begin
            w_m = M_MAX;
        end else begin
            w_m = r_num_el;
        end
    end

    // arithmetic around the rotator
    always_comb begin
        w_last    = ({1'b0, r_idx} == (w_m - NUMW'(1)));
        w_acc_rnd = r_acc + RND_HALF;
        w_prod    = $signed({1'b0, r_spacing}) * r_sin;
        if (w_res.sin_v > ONE_Q30) begin
            w_sclamp = ONE_Q30;
        end else if (w_res.sin_v < MONE_Q30) begin
            w_sclamp = MONE_Q30;
        end else begin
            w_sclamp = w_res.sin_v;
        end
    end

    assign w_out_free = !r_m_tvalid || m_axis_tready;
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_sin       = r_sin;
        n_step      = r_step;
        n_m_tvalid  = r_m_tvalid;
        n_m_tdata   = r_m_tdata;
        n_m_tlast   = r_m_tlast;
        w_req.start = 1'b0;
        w_req.phase = w_acc_rnd[ACCW-1:ACCW-PHW];
        s_axis_tready = (r_state == S_IDLE);

        if (r_m_tvalid && m_axis_tready) begin
            n_m_tvalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_req.start = 1'b1;
                    w_req.phase = {s_axis_tdata, 16'h0000};
                    n_idx       = '0;
                    n_acc       = '0;
                    n_state     = S_THETA;
                end
            end
            S_THETA: begin
                if (w_res.done) begin
                    n_sin   = w_sclamp[31:0];
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_step  = w_prod[ACCW-1:0];
                n_state = S_ELEM;
            end
            S_ELEM: begin
                w_req.start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (w_res.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {2'b00, to_q14(w_res.sin_v), to_q14(w_res.cos_v), r_idx};
                    n_m_tlast  = w_last;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDXW'(1);
                        n_acc   = r_acc + r_step;
                        n_state = S_ELEM;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_acc     <= n_acc;
        r_sin     <= n_sin;
        r_step    <= n_step;
        r_m_tdata <= n_m_tdata;
        r_m_tlast <= n_m_tlast;
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tlast  = r_m_tlast;

    // checks
    `USVG_ASSERT(a_no_done_idle, (r_state == S_IDLE) |-> !w_res.done, "rotator finished while idle")
    `USVG_ASSERT(a_idx_range, (r_state == S_ELEM) |-> ({1'b0, r_idx} < w_m), "element index past count")
    `USVG_ASSERT(a_last_idx, (m_axis_tvalid && m_axis_tlast) |-> ({1'b0, m_axis_tdata[IDXW-1:0]} == (w_m - NUMW'(1))), "tlast on wrong element")
    `USVG_ASSERT_ALWAYS(a_rst_idle, !$past(i_rst_n) |-> (r_state == S_IDLE && !r_m_tvalid), "not idle after reset")

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ula steering vector generator
// ----------------------------------------------------------------------------
// Angles are streamed in from a queue filled by the stimulus process. Each
// accepted angle runs through a local fixed-point cordic predictor that builds
// the expected element results. The monitor pops them in order and compares
// every result field of every output transaction. Register writes are issued
// only while the block is drained. The stimulus covers a directed set of angles
// and register extremes, then random phases with source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb
    import usvg_pkg::*;
();

    localparam int                  STAGES        = CORDIC_STAGES_DEF;
    localparam int                  ATAN_LEN      = 24;
    localparam int                  ELEM_LIMIT    = MAX_ELEMENTS_DEF;
    localparam int                  SETTLE_CYCLES = 1300;
    localparam int                  PHASE_ANGLES  = 56;
    localparam int                  PHASE_COUNT   = 8;
    localparam logic [CFG_IDXW-1:0] REG_UNKNOWN   = 8'hFF;

    // one expected element result
    typedef struct {
        logic [IDXW-1:0] index;
        logic [OUTW-1:0] re;
        logic [OUTW-1:0] im;
        logic            last;
    } t_element;

    // one pending register write
    typedef struct {
        logic [CFG_IDXW-1:0] index;
        logic [CFG_DW-1:0]   data;
    } t_reg_write;

    // dut ports
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [ANGW-1:0]     s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OTDW-1:0]     m_axis_tdata;
    logic                m_axis_tlast;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_IDXW-1:0] i_cfg_index   = '0;
    logic [CFG_DW-1:0]   i_cfg_data    = '0;

    // pending stimulus and expected element results
    logic [ANGW-1:0] angle_q[$];
    t_reg_write      reg_q[$];
    t_element        element_q[$];
    t_reg_write      cur_write;
    t_element        want_elem;

    // predictor copy of the registers
    logic [NUMW-1:0] model_num_elements = NUM_ELEMENTS_RST;
    logic [SPW-1:0]  model_spacing      = ELEMENT_SPACING_RST;

    int source_idle_pct = 0;
    int sink_stall_pct  = 0;
    int mismatch_count  = 0;

    ula_steering_vector_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // atan(2^-k) in 2^-32 turn units
    function automatic longint atan_step(input int k);
        case (k)
            0:       return 64'h2000_0000;
            1:       return 64'h12E4_051E;
            2:       return 64'h09FB_385B;
            3:       return 64'h0511_11D4;
            4:       return 64'h028B_0D43;
            5:       return 64'h0145_D7E1;
            6:       return 64'h00A2_F61E;
            7:       return 64'h0051_7C55;
            8:       return 64'h0028_BE53;
            9:       return 64'h0014_5F2F;
            10:      return 64'h000A_2F98;
            11:      return 64'h0005_17CC;
            12:      return 64'h0002_8BE6;
            13:      return 64'h0001_45F3;
            14:      return 64'h0000_A2F9;
            15:      return 64'h0000_517C;
            16:      return 64'h0000_28BE;
            17:      return 64'h0000_145F;
            18:      return 64'h0000_0A2F;
            19:      return 64'h0000_0517;
            20:      return 64'h0000_028B;
            21:      return 64'h0000_0145;
            22:      return 64'h0000_00A2;
            23:      return 64'h0000_0051;
            default: return 64'h0;
        endcase
    endfunction

    // cos and sin in q2.30 of a phase where 2^32 is one turn
    function automatic void cordic_rotate(input logic [PHW-1:0] ph,
                                          output longint cos_v, output longint sin_v);
        logic [PHW-1:0] shifted;
        logic [PHW-1:0] rem;
        logic [1:0]     quad;
        longint         x, y, z, dx, dy;
        int             k;
        // fold into one eighth turn around zero, remember the quadrant
        shifted = ph + EIGHTH;
        quad    = shifted[PHW-1:PHW-2];
        rem     = ph - {quad, 30'd0};
        z       = longint'($signed(rem));
        x       = GAIN_Q30;
        y       = 0;
        for (k = 0; k < STAGES && k < ATAN_LEN; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(k);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(k);
            end
        end
        // undo the quadrant fold
        case (quad)
            2'd1: begin
                cos_v = -y;
                sin_v = x;
            end
            2'd2: begin
                cos_v = -x;
                sin_v = -y;
            end
            2'd3: begin
                cos_v = y;
                sin_v = -x;
            end
            default: begin
                cos_v = x;
                sin_v = y;
            end
        endcase
    endfunction

    // q2.30 to q1.14, round half up and saturate
    function automatic logic [OUTW-1:0] round_to_q14(input longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 16384) begin
            r = 16384;
        end else if (r < -16384) begin
            r = -16384;
        end
        return r[OUTW-1:0];
    endfunction

    // expected element results for one accepted angle
    function automatic void predict_steering_vector(input logic [ANGW-1:0] angle);
        longint      cos_t, sin_t, spacing, prod, ec, es;
        logic [63:0] rounded;
        int          count, i;
        t_element    e;
        cordic_rotate({angle, 16'd0}, cos_t, sin_t);
        if (sin_t > ONE_Q30) begin
            sin_t = ONE_Q30;
        end else if (sin_t < MONE_Q30) begin
            sin_t = MONE_Q30;
        end
        // element count of zero acts as one, above the maximum acts as the maximum
        count = model_num_elements;
        if (count < 1) begin
            count = 1;
        end else if (count > ELEM_LIMIT) begin
            count = ELEM_LIMIT;
        end
        spacing = model_spacing;
        for (i = 0; i < count; i++) begin
            prod    = i * spacing * sin_t;
            rounded = prod + 512;
            cordic_rotate(rounded[41:10], ec, es);
            e.index = i[IDXW-1:0];
            e.re    = round_to_q14(ec);
            e.im    = round_to_q14(es);
            e.last  = (i == count - 1);
            element_q = {element_q, e};
        end
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // driver: angle and register write transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_steering_vector(s_axis_tdata);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_NUM_ELEMENTS:    model_num_elements = i_cfg_data[NUMW-1:0];
                    REG_ELEMENT_SPACING: model_spacing = i_cfg_data;
                    default: ;
                endcase
            end
            // next angle, with random source gaps
            if (!s_axis_tvalid || s_axis_tready) begin
                if (angle_q.size() != 0 && $urandom_range(0, 99) >= source_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= angle_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            // next register write
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_q.size() != 0) begin
                    cur_write = reg_q.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= cur_write.index;
                    i_cfg_data  <= cur_write.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random sink stalls and element checks
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (element_q.size() == 0) begin
                $display("%0t: unexpected element result, expected none actual %h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want_elem = element_q.pop_front();
                compare_field("element_index", want_elem.index, m_axis_tdata[5:0]);
                compare_field("real_part", $signed(want_elem.re),
                              $signed(m_axis_tdata[21:6]));
                compare_field("imag_part", $signed(want_elem.im),
                              $signed(m_axis_tdata[37:22]));
                compare_field("last", want_elem.last, m_axis_tlast);
            end
        end
    end

    function automatic void write_reg(input logic [CFG_IDXW-1:0] index,
                                      input logic [CFG_DW-1:0] data);
        t_reg_write w;
        w.index = index;
        w.data  = data;
        reg_q = {reg_q, w};
    endfunction

    // wait until all stimulus is accepted and every expected result has come
    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (angle_q.size() != 0 || s_axis_tvalid || reg_q.size() != 0
                   || i_cfg_valid || element_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        int          phase, n, pick;
        logic [15:0] angle;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: axis angles, extremes, one lsb off zero, +-45 and 30 degrees
        angle_q = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
                    16'h0001, 16'hFFFF, 16'h2000, 16'hE000, 16'h1555};
        settle();

        // element count zero with upper data bits set, widest spacing
        write_reg(REG_NUM_ELEMENTS, 16'hFF80);
        write_reg(REG_ELEMENT_SPACING, 16'hFFFF);
        settle();
        angle_q = '{16'h4000, 16'hFFFF, 16'h3039};
        settle();

        // element count above the maximum, zero spacing
        write_reg(REG_NUM_ELEMENTS, 16'd127);
        write_reg(REG_ELEMENT_SPACING, 16'h0000);
        settle();
        angle_q = '{16'h4000, 16'h8000};
        settle();

        // full array at one wavelength, unknown register must be ignored
        write_reg(REG_NUM_ELEMENTS, 16'd64);
        write_reg(REG_ELEMENT_SPACING, 16'h1000);
        write_reg(REG_UNKNOWN, 16'h0003);
        settle();
        angle_q = '{16'h4000, 16'h0AAB, 16'hF000};
        settle();

        write_reg(REG_ELEMENT_SPACING, 16'hFFFF);
        settle();
        angle_q = '{16'h7FFF, 16'h4000};
        settle();

        // random phases over the idling modes
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 4)
                0: begin
                    source_idle_pct = 0;
                    sink_stall_pct  = 0;
                end
                1: begin
                    source_idle_pct = 49;
                    sink_stall_pct  = 0;
                end
                2: begin
                    source_idle_pct = 0;
                    sink_stall_pct  = 49;
                end
                default: begin
                    source_idle_pct = 34;
                    sink_stall_pct  = 34;
                end
            endcase
            if (phase == 3) begin
                write_reg(REG_NUM_ELEMENTS, 16'd64);
                write_reg(REG_ELEMENT_SPACING, 16'hFFFF);
            end else if (phase == 7) begin
                write_reg(REG_NUM_ELEMENTS, 16'd100);
                write_reg(REG_ELEMENT_SPACING, 16'($urandom));
            end else begin
                write_reg(REG_NUM_ELEMENTS, {9'($urandom), 7'($urandom_range(1, 16))});
                write_reg(REG_ELEMENT_SPACING, 16'($urandom));
                if ($urandom_range(0, 3) == 0) begin
                    write_reg(REG_UNKNOWN, 16'($urandom));
                end
            end
            settle();
            for (n = 0; n < PHASE_ANGLES; n++) begin
                pick = $urandom_range(0, 9);
                // mostly uniform angles, some near broadside and endfire
                if (pick == 0) begin
                    angle = 16'h4000 + 16'($urandom_range(0, 15)) - 16'd8;
                end else if (pick == 1) begin
                    angle = 16'hC000 + 16'($urandom_range(0, 15)) - 16'd8;
                end else if (pick == 2) begin
                    angle = 16'($urandom_range(0, 15)) - 16'd8;
                end else begin
                    angle = 16'($urandom);
                end
                angle_q = {angle_q, angle};
            end
            settle();
        end

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run limit
    initial begin
        #(50_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/usvg_pkg.sv
rtl/usvg_cordic.sv
rtl/ula_steering_vector_generator.sv
tb/tb.sv
